[rtl/lmsd_pkg.sv]
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared types, codes and microcode table for the LED matrix scan driver.
// ----------------------------------------------------------------------------
package lmsd_pkg;

    localparam int ROWS_DEF    = 32;
    localparam int COLUMNS_DEF = 32;
    localparam int SEL_W       = 4;
    localparam int STEP_W      = 4;

    localparam logic [2:0] FN_SET   = 3'd0;
    localparam logic [2:0] FN_FILL  = 3'd1;
    localparam logic [2:0] FN_BLANK = 3'd2;
    localparam logic [2:0] FN_START = 3'd3;
    localparam logic [2:0] FN_TICK  = 3'd4;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_CLR   = 4'd0;
    localparam t_step S_IDLE  = 4'd1;
    localparam t_step S_SET   = 4'd2;
    localparam t_step S_FILL  = 4'd3;
    localparam t_step S_BLANK = 4'd4;
    localparam t_step S_START = 4'd5;
    localparam t_step S_RD    = 4'd6;
    localparam t_step S_TICK  = 4'd7;
    localparam t_step S_EMIT  = 4'd8;

    localparam logic [2:0] JC_NEXT     = 3'd0;
    localparam logic [2:0] JC_GOTO     = 3'd1;
    localparam logic [2:0] JC_SWEEP    = 3'd2;
    localparam logic [2:0] JC_EMIT     = 3'd3;
    localparam logic [2:0] JC_DISPATCH = 3'd4;

    // bit 0 red, bit 1 green, bit 2 blue
    typedef logic [2:0] t_flags;

    typedef struct packed {
        logic [2:0] func;
        logic [5:0] x;
        logic [5:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic             upper_red;
        logic             upper_green;
        logic             upper_blue;
        logic             lower_red;
        logic             lower_green;
        logic             lower_blue;
        logic [SEL_W-1:0] row_select;
        logic             shift_clock;
        logic             latch;
        logic             blank_out;
        logic             busy_res;
        logic             error;
    } t_out_item;

    typedef struct packed {
        t_flags           upper;
        t_flags           lower;
        logic [SEL_W-1:0] row_select;
        logic             shift_clock;
        logic             latch;
        logic             blank_out;
    } t_pins;

    typedef struct packed {
        logic       acc;
        logic       we;
        logic       wzero;
        logic       asweep;
        logic       rd;
        logic       start;
        logic       tick;
        logic       emit;
        logic [2:0] jc;
        t_step      target;
    } t_uop;

    function automatic t_uop ucode(input t_step step);
        t_uop u;
        u = '0;
        unique case (step)
            S_CLR: begin
                u.we = 1'b1; u.wzero = 1'b1; u.asweep = 1'b1;
                u.jc = JC_SWEEP; u.target = S_IDLE;
            end
            S_IDLE: begin
                u.acc = 1'b1; u.jc = JC_DISPATCH; u.target = S_IDLE;
            end
            S_SET: begin
                u.we = 1'b1; u.jc = JC_GOTO; u.target = S_EMIT;
            end
            S_FILL: begin
                u.we = 1'b1; u.asweep = 1'b1;
                u.jc = JC_SWEEP; u.target = S_EMIT;
            end
            S_BLANK: begin
                u.we = 1'b1; u.wzero = 1'b1; u.asweep = 1'b1;
                u.jc = JC_SWEEP; u.target = S_EMIT;
            end
            S_START: begin
                u.start = 1'b1; u.jc = JC_GOTO; u.target = S_EMIT;
            end
            S_RD: begin
                u.rd = 1'b1; u.jc = JC_NEXT; u.target = S_TICK;
            end
            S_TICK: begin
                u.tick = 1'b1; u.jc = JC_NEXT; u.target = S_EMIT;
            end
            S_EMIT: begin
                u.emit = 1'b1; u.jc = JC_EMIT; u.target = S_IDLE;
            end
            default: begin
                u.jc = JC_GOTO; u.target = S_IDLE;
            end
        endcase
        return u;
    endfunction

    function automatic t_step dispatch(input logic [2:0] func);
        t_step s;
        unique case (func)
            FN_SET:   s = S_SET;
            FN_FILL:  s = S_FILL;
            FN_BLANK: s = S_BLANK;
            FN_START: s = S_START;
            FN_TICK:  s = S_RD;
            default:  s = S_EMIT;
        endcase
        return s;
    endfunction

endpackage

[rtl/lmsd_in_if.sv]
// ----------------------------------------------------------------------------
// lmsd_in_if
// Command channel: valid/ready with one command item per transfer.
// ----------------------------------------------------------------------------
interface lmsd_in_if;
    import lmsd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/lmsd_out_if.sv]
// ----------------------------------------------------------------------------
// lmsd_out_if
// Result channel: valid/ready with one pin/status item per transfer.
// ----------------------------------------------------------------------------
interface lmsd_out_if;
    import lmsd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/lmsd_seq.sv]
// ----------------------------------------------------------------------------
// lmsd_seq
// Step counter and microcode table lookup with conditional jumps.
// ----------------------------------------------------------------------------
module lmsd_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [2:0]      i_func,
    input  logic            i_sweep_last,
    input  logic            i_out_free,
    output lmsd_pkg::t_uop  o_uop
);
    import lmsd_pkg::*;

    t_step r_step;
    t_step n_step;
    t_uop  w_uop;

    assign w_uop = ucode(r_step);
    assign o_uop = w_uop;

    always_comb begin
        unique case (w_uop.jc)
            JC_NEXT:     n_step = r_step + t_step'(1);
            JC_GOTO:     n_step = w_uop.target;
            JC_SWEEP:    n_step = i_sweep_last ? w_uop.target : r_step;
            JC_EMIT:     n_step = i_out_free ? w_uop.target : r_step;
            JC_DISPATCH: n_step = i_in_valid ? dispatch(i_func) : r_step;
            default:     n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end
endmodule

[rtl/lmsd_store.sv]
// ----------------------------------------------------------------------------
// lmsd_store
// Frame store RAM: one write port, two registered read ports, sweep counter.
// ----------------------------------------------------------------------------
module lmsd_store #(
    parameter int ROWS    = lmsd_pkg::ROWS_DEF,
    parameter int COLUMNS = lmsd_pkg::COLUMNS_DEF,
    localparam int PIXELS = ROWS * COLUMNS,
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic             i_wzero,
    input  logic             i_asweep,
    input  lmsd_pkg::t_flags i_wflags,
    input  logic [AW-1:0]    i_waddr,
    input  logic             i_rd,
    input  logic [AW-1:0]    i_upper_addr,
    input  logic [AW-1:0]    i_lower_addr,
    output logic             o_sweep_last,
    output lmsd_pkg::t_flags o_upper,
    output lmsd_pkg::t_flags o_lower
);
    import lmsd_pkg::*;

    t_flags        mem [PIXELS];
    logic [AW-1:0] r_sweep;
    logic [AW-1:0] w_addr;
    t_flags        w_data;

    assign o_sweep_last = (r_sweep == AW'(PIXELS - 1));
    assign w_addr       = i_asweep ? r_sweep : i_waddr;
    assign w_data       = i_wzero ? t_flags'(0) : i_wflags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_we && i_asweep) begin
            r_sweep <= o_sweep_last ? '0 : r_sweep + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[w_addr] <= w_data;
        end
        if (i_rd) begin
            o_upper <= mem[i_upper_addr];
            o_lower <= mem[i_lower_addr];
        end
    end
endmodule

[rtl/lmsd_scan.sv]
// ----------------------------------------------------------------------------
// lmsd_scan
// Row/column/phase scan counters and the panel pin word.
// ----------------------------------------------------------------------------
module lmsd_scan #(
    parameter int ROWS    = lmsd_pkg::ROWS_DEF,
    parameter int COLUMNS = lmsd_pkg::COLUMNS_DEF,
    localparam int PIXELS = ROWS * COLUMNS,
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_tick,
    input  lmsd_pkg::t_flags i_upper,
    input  lmsd_pkg::t_flags i_lower,
    output logic [AW-1:0]    o_upper_addr,
    output logic [AW-1:0]    o_lower_addr,
    output lmsd_pkg::t_pins  o_pins,
    output logic             o_busy
);
    import lmsd_pkg::*;

    localparam int HALF = ROWS / 2;
    localparam int RW   = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int CW   = $clog2(COLUMNS + 1);

    localparam logic [2:0] PH_DATA    = 3'd0;
    localparam logic [2:0] PH_CLK     = 3'd1;
    localparam logic [2:0] PH_ADDR    = 3'd2;
    localparam logic [2:0] PH_OE      = 3'd3;
    localparam logic [2:0] PH_LAT     = 3'd4;
    localparam logic [2:0] PH_UNLAT   = 3'd5;
    localparam logic [2:0] PH_UNBLANK = 3'd6;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [CW-1:0] w_col_inc;
    logic [2:0]    r_phase;
    logic          r_busy;
    t_pins         r_pins;

    assign w_col_inc    = r_col + CW'(1);
    assign o_upper_addr = AW'(int'(r_row) * COLUMNS + int'(r_col));
    assign o_lower_addr = AW'((int'(r_row) + HALF) * COLUMNS + int'(r_col));
    assign o_pins       = r_pins;
    assign o_busy       = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_phase <= PH_DATA;
            r_busy  <= 1'b0;
            r_pins  <= '0;
        end else if (i_start) begin
            r_row   <= '0;
            r_col   <= '0;
            r_phase <= PH_DATA;
            r_busy  <= 1'b1;
        end else if (i_tick && r_busy) begin
            unique case (r_phase)
                PH_DATA: begin
                    r_pins.upper       <= i_upper;
                    r_pins.lower       <= i_lower;
                    r_pins.shift_clock <= 1'b0;
                    r_phase            <= PH_CLK;
                end
                PH_CLK: begin
                    r_pins.shift_clock <= 1'b1;
                    r_col              <= w_col_inc;
                    r_phase            <= (w_col_inc == CW'(COLUMNS)) ? PH_ADDR : PH_DATA;
                end
                PH_ADDR: begin
                    r_pins.row_select  <= SEL_W'(r_row);
                    r_pins.shift_clock <= 1'b0;
                    r_phase            <= PH_OE;
                end
                PH_OE: begin
                    r_pins.blank_out <= 1'b1;
                    r_phase          <= PH_LAT;
                end
                PH_LAT: begin
                    r_pins.latch <= 1'b1;
                    r_phase      <= PH_UNLAT;
                end
                PH_UNLAT: begin
                    r_pins.latch <= 1'b0;
                    r_phase      <= PH_UNBLANK;
                end
                default: begin
                    r_pins.blank_out <= 1'b0;
                    r_phase          <= PH_DATA;
                    r_col            <= '0;
                    if (r_row == RW'(HALF - 1)) begin
                        r_row  <= '0;
                        r_busy <= 1'b0;
                    end else begin
                        r_row <= r_row + RW'(1);
                    end
                end
            endcase
        end
    end
endmodule

[rtl/led_matrix_scan_driver.sv]
// ----------------------------------------------------------------------------
// led_matrix_scan_driver
// Flow: set writes one pixel and start restarts the scan; tick reads the store,
// then steps the scan; fill and blank sweep the store, one entry per cycle; unused
// codes go straight to emit. Every command ends in an emit step that waits for a
// free result slot; a new command is taken only back in the idle step after it.
// Reset: synchronous; a clearing pass over the frame store runs first, input
// not ready until it ends. Pins, scan counters and result valid cleared.
// ----------------------------------------------------------------------------
module led_matrix_scan_driver #(
    parameter int ROWS    = lmsd_pkg::ROWS_DEF,
    parameter int COLUMNS = lmsd_pkg::COLUMNS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lmsd_in_if.sink           i_in,
    lmsd_out_if.source        o_out
);
    import lmsd_pkg::*;

    localparam int PIXELS = ROWS * COLUMNS;
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    t_uop          w_uop;
    t_in_item      r_item;
    t_out_item     r_out;
    logic          r_out_valid;
    logic          w_out_free;
    logic          w_sweep_last;
    logic          w_in_range;
    logic          w_we;
    t_flags        w_flags;
    logic [AW-1:0] w_xy_addr;
    logic [AW-1:0] w_upper_addr;
    logic [AW-1:0] w_lower_addr;
    t_flags        w_upper;
    t_flags        w_lower;
    t_pins         w_pins;
    logic          w_busy;

    assign i_in.ready  = w_uop.acc;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign w_in_range = (int'(r_item.x) < COLUMNS) && (int'(r_item.y) < ROWS);
    assign w_flags    = {(r_item.blue != '0), (r_item.green != '0), (r_item.red != '0)};
    assign w_xy_addr  = AW'(int'(r_item.y) * COLUMNS + int'(r_item.x));
    assign w_we       = w_uop.we && (w_uop.asweep || w_in_range);

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
    end

    lmsd_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_func       (i_in.data.func),
        .i_sweep_last (w_sweep_last),
        .i_out_free   (w_out_free),
        .o_uop        (w_uop)
    );

    lmsd_store #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_we         (w_we),
        .i_wzero      (w_uop.wzero),
        .i_asweep     (w_uop.asweep),
        .i_wflags     (w_flags),
        .i_waddr      (w_xy_addr),
        .i_rd         (w_uop.rd),
        .i_upper_addr (w_upper_addr),
        .i_lower_addr (w_lower_addr),
        .o_sweep_last (w_sweep_last),
        .o_upper      (w_upper),
        .o_lower      (w_lower)
    );

    lmsd_scan #(.ROWS(ROWS), .COLUMNS(COLUMNS)) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_uop.start),
        .i_tick       (w_uop.tick),
        .i_upper      (w_upper),
        .i_lower      (w_lower),
        .o_upper_addr (w_upper_addr),
        .o_lower_addr (w_lower_addr),
        .o_pins       (w_pins),
        .o_busy       (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uop.emit && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uop.emit && w_out_free) begin
            r_out.upper_red   <= w_pins.upper[0];
            r_out.upper_green <= w_pins.upper[1];
            r_out.upper_blue  <= w_pins.upper[2];
            r_out.lower_red   <= w_pins.lower[0];
            r_out.lower_green <= w_pins.lower[1];
            r_out.lower_blue  <= w_pins.lower[2];
            r_out.row_select  <= w_pins.row_select;
            r_out.shift_clock <= w_pins.shift_clock;
            r_out.latch       <= w_pins.latch;
            r_out.blank_out   <= w_pins.blank_out;
            r_out.busy_res    <= w_busy;
            r_out.error       <= (r_item.func == FN_SET) && !w_in_range;
        end
    end

`ifndef SYNTH
    a_no_write_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && i_in.ready))
        else $error("frame store written while taking commands");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in.ready)
        else $error("command taken before clearing pass");

    a_latch_blanked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.latch) |-> o_out.data.blank_out)
        else $error("latch raised while display enabled");
`endif
endmodule
